FILE: design/cvp_pkg.sv
// Shared constants and types for the CSV column integer parser.
package cvp_pkg;

    localparam int MAX_FIELD_CHARS = 10;
    localparam int CNT_W           = $clog2(MAX_FIELD_CHARS + 1);
    localparam int BYTE_W          = 8;
    localparam int VALUE_W         = 32;
    localparam int PROD_W          = VALUE_W + 4;

    localparam logic [VALUE_W-1:0] MAG_CAP = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] POS_MAX = 32'h7FFF_FFFF;

    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_VTAB    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF      = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_HEADER  = 1'b1;

    // Commands from the stream control to the field converter.
    typedef struct packed {
        logic clear;
        logic take;
    } cvp_ctl_t;

endpackage

FILE: design/cvp_field_conv.sv
// Field converter: atoi-style digit accumulation with saturation.
module cvp_field_conv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cvp_pkg::cvp_ctl_t            ctl,
    input  logic [cvp_pkg::BYTE_W-1:0]   in_byte,
    output logic [cvp_pkg::VALUE_W-1:0]  value
);
    import cvp_pkg::*;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 neg_reg, neg_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;

    logic                 is_digit;
    logic                 is_blank;
    logic                 is_sign;
    logic [PROD_W-1:0]    mag_ext;
    logic [PROD_W-1:0]    prod;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR)
                   || (in_byte == CH_VTAB) || (in_byte == CH_FF);
    assign is_sign  = (in_byte == CH_PLUS) || (in_byte == CH_MINUS);

    // mag * 10 + digit as two shifts and two adds
    assign mag_ext = {{(PROD_W-VALUE_W){1'b0}}, mag_reg};
    assign prod    = (mag_ext << 3) + (mag_ext << 1) + PROD_W'(in_byte[3:0]);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        if (ctl.clear)
        begin
            phase_next = PH_LEAD;
            count_next = '0;
            neg_next   = 1'b0;
            mag_next   = '0;
        end
        else if (ctl.take && (count_reg < CNT_W'(MAX_FIELD_CHARS)))
        begin
            count_next = count_reg + CNT_W'(1);
            if (phase_reg != PH_DONE)
            begin
                priority if (is_digit)
                begin
                    mag_next   = (prod > PROD_W'(MAG_CAP)) ? MAG_CAP : prod[VALUE_W-1:0];
                    phase_next = PH_DIGITS;
                end
                else if ((phase_reg == PH_LEAD) && is_blank)
                begin
                    phase_next = PH_LEAD;
                end
                else if ((phase_reg == PH_LEAD) && is_sign)
                begin
                    neg_next   = (in_byte == CH_MINUS);
                    phase_next = PH_SIGN;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            count_reg <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

    // signed result with saturation at both limits
    always_comb
    begin
        if (neg_reg)
            value = (mag_reg >= MAG_CAP) ? MAG_CAP : (VALUE_W'(0) - mag_reg);
        else
            value = (mag_reg >= MAG_CAP) ? POS_MAX : mag_reg;
    end

endmodule

FILE: design/csv_column_integer_parser.sv
// Top level: CSV column extractor with atoi conversion of the selected field.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata[7:0] in_byte
//  m_*     | out       | m_tvalid/m_tready  | m_tdata[31:0] value (signed)
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index 0 field_select, 1 skip_header
//
// One byte per cycle sustained while no result is held; a terminator passes through the
// input register, then the state update writes its value into the result register.
// rst_n clears all parse state and loads field_select 0, skip_header 1.
// A held result stalls the byte in the input register; the input still takes
// a word in the cycle the result is taken.
module csv_column_integer_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] in_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [31:0] value
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cvp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    import cvp_pkg::*;

    logic                 in_vld_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 out_vld_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [7:0]           field_select_reg;
    logic                 skip_header_reg;
    logic                 header_done_reg;
    logic [7:0]           field_index_reg, field_index_next;

    logic                 stage_go;
    logic                 skipping;
    logic                 is_comma;
    logic                 is_newline;
    logic                 is_term;
    logic                 selected;
    logic                 emit;
    cvp_ctl_t             ctl;
    logic [VALUE_W-1:0]   conv_value;

    assign cfg_ready = 1'b1;
    assign stage_go  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || stage_go;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_value_reg;

    assign skipping   = !header_done_reg && skip_header_reg;
    assign is_comma   = (in_byte_reg == CH_COMMA);
    assign is_newline = (in_byte_reg == CH_NEWLINE);
    assign is_term    = is_comma || is_newline;
    assign selected   = (field_index_reg == field_select_reg);
    assign emit       = stage_go && !skipping && is_term && selected;

    assign ctl.clear = stage_go && !skipping && is_term;
    assign ctl.take  = stage_go && !skipping && !is_term && selected;

    always_comb
    begin
        field_index_next = field_index_reg;
        if (stage_go && !skipping)
        begin
            if (is_newline)
                field_index_next = '0;
            else if (is_comma && (field_index_reg != 8'hFF))
                field_index_next = field_index_reg + 8'd1;
        end
    end

    cvp_field_conv u_conv (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .in_byte (in_byte_reg),
        .value   (conv_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            field_select_reg <= '0;
            skip_header_reg  <= 1'b1;
            header_done_reg  <= 1'b0;
            field_index_reg  <= '0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (stage_go)
                out_vld_reg <= emit;
            else if (m_tready)
                out_vld_reg <= 1'b0;
            if (stage_go && is_newline)
                header_done_reg <= 1'b1;
            field_index_reg <= field_index_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FIELD_SELECT: field_select_reg <= cfg_data;
                    CFG_SKIP_HEADER:  skip_header_reg  <= cfg_data[0];
                    default:          field_select_reg <= field_select_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (emit)
            out_value_reg <= conv_value;
    end

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> s_tready)
        else $error("input register empty but not ready");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid)
        else $error("emitted value not presented");

    a_newline_resets_index: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && !skipping && is_newline) |=> (field_index_reg == 8'd0))
        else $error("field index not cleared by newline");

    a_skip_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && skipping) |=> !m_tvalid)
        else $error("header byte produced output");

endmodule

FILE: bench/tb_top.sv
// Testbench for the CSV column integer parser: random CSV rows checked against a column predictor.
`timescale 1ns / 100ps

module tb_top;

    import cvp_pkg::*;

    typedef enum logic [1:0] {PH_BLANK, PH_SIGN, PH_DIGITS, PH_DONE} conv_phase_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    // Column tracker state, mirrors what the parser should hold
    logic [7:0]           sel_col   = 8'd0;
    logic                 skip_hdr  = 1'b1;
    logic                 hdr_seen  = 1'b0;
    logic [7:0]           col_idx   = 8'd0;
    logic [3:0]           taken     = 4'd0;
    conv_phase_t          phase     = PH_BLANK;
    logic                 neg       = 1'b0;
    logic [31:0]          mag       = '0;

    logic [31:0]          column_values[$];
    int                   bytes_sent   = 0;
    int                   values_seen  = 0;
    int                   mismatches   = 0;
    bit                   in_idle_en   = 1'b1;
    bit                   out_idle_en  = 1'b1;
    int                   hold_req     = 0;

    string limit_texts[7] = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                              "99999999999", "+0000000000123", "4294967296"};

    csv_column_integer_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Advance the column tracker by one byte; returns 1 when a value is emitted.
    function automatic bit parse_csv_byte(input logic [7:0] c, output logic [31:0] val);
        logic [35:0] prod;
        bit          hit;
        val = '0;
        if (!hdr_seen && skip_hdr)
        begin
            if (c == CH_NEWLINE)
                hdr_seen = 1'b1;
            return 1'b0;
        end
        if (c == CH_COMMA || c == CH_NEWLINE)
        begin
            hit = (col_idx == sel_col);
            if (hit)
            begin
                if (neg)
                    val = (mag >= MAG_CAP) ? MAG_CAP : 32'd0 - mag;
                else
                    val = (mag >= MAG_CAP) ? POS_MAX : mag;
            end
            taken = '0;
            phase = PH_BLANK;
            neg   = 1'b0;
            mag   = '0;
            if (c == CH_COMMA)
            begin
                if (col_idx != 8'hFF)
                    col_idx = col_idx + 8'd1;
            end
            else
            begin
                col_idx  = '0;
                hdr_seen = 1'b1;
            end
            return hit;
        end
        if (col_idx == sel_col && int'(taken) < MAX_FIELD_CHARS)
        begin
            taken = taken + 4'd1;
            if (phase != PH_DONE)
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    prod  = 36'(mag) * 36'd10 + 36'(c - CH_ZERO);
                    mag   = (prod > 36'(MAG_CAP)) ? MAG_CAP : prod[31:0];
                    phase = PH_DIGITS;
                end
                else if (phase == PH_BLANK && (c == CH_SPACE || c == CH_TAB || c == CH_CR
                                               || c == CH_VTAB || c == CH_FF))
                begin
                    // skip leading whitespace
                end
                else if (phase == PH_BLANK && (c == CH_PLUS || c == CH_MINUS))
                begin
                    neg   = (c == CH_MINUS);
                    phase = PH_SIGN;
                end
                else
                    phase = PH_DONE;
            end
        end
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int          gap;
        logic [31:0] v;
        gap = in_idle_en ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        if (parse_csv_byte(b, v))
            column_values = {column_values, v};
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic stop_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Hold the sender until every value has come out, then let the pipeline settle.
    task automatic drain_results();
        stop_input();
        while (column_values.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_FIELD_SELECT)
            sel_col = data;
        else if (idx == CFG_SKIP_HEADER)
            skip_hdr = data[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_VTAB;
            default: return CH_FF;
        endcase
    endfunction

    task automatic send_value_cell();
        int n;
        case ($urandom_range(0, 9))
            0: ; // empty field
            1:
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            2: send_text(limit_texts[$urandom_range(0, 6)]);
            3:
            begin
                // blank after the sign ends the conversion
                send_byte(blank_char());
                send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                send_byte(blank_char());
                send_text("42");
            end
            default:
            begin
                n = $urandom_range(0, 2);
                repeat (n) send_byte(blank_char());
                case ($urandom_range(0, 5))
                    0, 1:    send_byte(CH_MINUS);
                    2:       send_byte(CH_PLUS);
                    default: ;
                endcase
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 13) : $urandom_range(1, 5);
                repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 4) == 0)
                begin
                    send_byte(8'h61 + 8'($urandom_range(0, 25)));
                    send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                end
            end
        endcase
    endtask

    task automatic send_filler_cell(input bit wide);
        int n;
        n = wide ? ($urandom_range(0, 9) == 0) : $urandom_range(0, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 1))
                send_byte(8'h41 + 8'($urandom_range(0, 25)));
            else
                send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic send_row(input int n_cols);
        for (int col = 0; col < n_cols; col++)
        begin
            if (col > 0)
                send_byte(CH_COMMA);
            if (col == int'(sel_col) || (sel_col == 8'hFF && col >= 255))
                send_value_cell();
            else
                send_filler_cell(n_cols > 16);
        end
        send_byte(CH_NEWLINE);
    endtask

    task automatic test_directed();
        write_reg(CFG_SKIP_HEADER, 8'd1);
        write_reg(CFG_FIELD_SELECT, 8'd0);
        send_text("H,x\n");           // header line, discarded
        send_text("\t-0042,x\n");
        send_byte(8'h00);             // zero byte ends the conversion
        send_byte(CH_NEWLINE);
        send_byte(8'hFF);
        send_text("+\n");
        send_text(",\n");             // empty selected field
        send_text("- 5\n");
    endtask

    task automatic test_random_rows(input logic [7:0] col, input logic skip, input int budget,
                                    input bit idle_in, input bit idle_out);
        int start;
        int n_cols;
        drain_results();
        write_reg(CFG_FIELD_SELECT, col);
        write_reg(CFG_SKIP_HEADER, {7'd0, skip});
        in_idle_en  = idle_in;
        out_idle_en = idle_out;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            if (sel_col < 8'd16)
                n_cols = int'(sel_col) + $urandom_range(0, 3);
            else
                n_cols = int'(sel_col) + $urandom_range(1, 4);
            send_row(n_cols);
            if ($urandom_range(0, 24) == 0)
                drain_results();
            if ($urandom_range(0, 9) == 0)
                in_idle_en = !in_idle_en;
        end
    endtask

    // Stall the output long enough for the parser to back up into its input.
    task automatic test_backpressure();
        drain_results();
        write_reg(CFG_FIELD_SELECT, 8'd0);
        in_idle_en  = 1'b0;
        out_idle_en = 1'b1;
        hold_req    = 300;
        repeat (60)
        begin
            send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            send_byte(CH_NEWLINE);
        end
    endtask

    task automatic test_unterminated_tail();
        send_text("123");
    endtask

    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            else
                stall = out_idle_en ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin : value_check
        logic [31:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (column_values.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected value, expected none, got %0d",
                         $time, $signed(m_tdata));
            end
            else
            begin
                want = column_values.pop_front();
                values_seen++;
                if (m_tdata !== want)
                begin
                    mismatches++;
                    $display("%0t: value mismatch, expected %0d, got %0d",
                             $time, $signed(want), $signed(m_tdata));
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_rows(8'd0, 1'b1, 300, 1'b1, 1'b1);
        test_random_rows(8'd1, 1'b0, 200, 1'b0, 1'b0);
        test_random_rows(8'd2, 1'b1, 200, 1'b1, 1'b0);
        test_random_rows(8'd254, 1'b0, 1, 1'b1, 1'b1);
        test_random_rows(8'd255, 1'b1, 1, 1'b0, 1'b1);
        test_backpressure();
        test_random_rows(8'd5, 1'b0, 120, 1'b1, 1'b1);
        test_unterminated_tail();

        stop_input();
        while (column_values.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Streamed %0d bytes and compared %0d column values", bytes_sent, values_seen);
        $display("Columns 0, 1, 2, 5, 254 and 255, header skip on and off, long output stall");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
